### sv/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// shared types and codes for the sorted array table
// ----------------------------------------------------------------------------
package sat_pkg;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_SEARCH     = 3'd1,
    OP_REMOVE_MIN = 3'd2,
    OP_REMOVE_MAX = 3'd3,
    OP_REMOVE_KEY = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_BELOW,
    RD_AT,
    RD_ABOVE
  } rd_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    ld_val;
    ptr_op_t ptr_op;
    rd_sel_t rd_sel;
    logic    we;
    logic    wr_val;
    cnt_op_t cnt_op;
    logic    res_clr;
    logic    res_set;
    status_t res_status;
    logic    res_hit;
    logic    out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic ptr_zero;
    logic ptr_end;
    logic ptr_last;
    logic full;
    logic empty;
  } dp_sts_t;

endpackage

### sv/sorted_array_table.sv
// ----------------------------------------------------------------------------
// sorted_array_table
// fixed-capacity table of signed values kept in ascending order
// ----------------------------------------------------------------------------
// usage:
//   input transfers carry an operation on s_tuser and a value on s_tdata;
//   each one yields exactly one result transfer on m_tdata (status, found,
//   position, count). one operation is in flight at a time.
// work per operation:
//   remove max, rejected and undefined operations need no walk; insert
//   shifts the larger entries up from the top until the new value fits;
//   search walks up from entry 0 to a hit or to the count; remove min shifts
//   all entries down; remove by key searches and on a hit shifts the entries
//   above it down. a walk visits the single entry memory one entry per cycle.
// handshake: s_tready returns in the cycle after the result is loaded into
//   the output register, so a waiting result does not block the next
//   transfer.
// a stalled m_tready holds the result; a finished walk then waits for the
//   output register to free up.
// reset clears the count (empty table) and the output valid; no memory
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_array_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], found[2], position[8:3], count[15:9]
);

  sat_pkg::dp_cmd_t cmd;
  sat_pkg::dp_sts_t sts;
  sat_pkg::status_t status;
  logic             found;
  logic [5:0]       position;
  logic [6:0]       count;

  sat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .op_in   (sat_pkg::op_t'(s_tuser)),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  sat_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .in_value($signed(s_tdata)),
    .status  (status),
    .found   (found),
    .position(position),
    .count   (count)
  );

  assign m_tdata = {count, position, found, status};

endmodule

### sv/sat_ram.sv
// ----------------------------------------------------------------------------
// sat_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sat_dp.sv
// ----------------------------------------------------------------------------
// sat_dp
// datapath: entry memory, walk pointer, count, compare and result registers
// ----------------------------------------------------------------------------
module sat_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sat_pkg::dp_cmd_t       cmd,
  output sat_pkg::dp_sts_t       sts,
  input  logic signed [31:0]     in_value,
  output sat_pkg::status_t       status,
  output logic                   found,
  output logic [5:0]             position,
  output logic [6:0]             count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] val;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      ptr_next;
  logic [CW-1:0]      cnt;
  logic [AW-1:0]      raddr;
  logic [31:0]        wdata;
  logic [31:0]        rdata;
  sat_pkg::status_t   res_status;
  logic               res_found;
  logic [CW-1:0]      res_pos;

  always_comb begin
    case (cmd.ptr_op)
      sat_pkg::PTR_ZERO:  ptr_next = '0;
      sat_pkg::PTR_COUNT: ptr_next = cnt;
      sat_pkg::PTR_INC:   ptr_next = ptr + 1'b1;
      sat_pkg::PTR_DEC:   ptr_next = ptr - 1'b1;
      default:            ptr_next = ptr;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      sat_pkg::RD_BELOW: raddr = AW'(ptr_next - 1'b1);
      sat_pkg::RD_ABOVE: raddr = AW'(ptr_next + 1'b1);
      default:           raddr = AW'(ptr_next);
    endcase
  end

  assign wdata = cmd.wr_val ? val : rdata;

  sat_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.we),
    .waddr(AW'(ptr)),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.gt       = $signed(rdata) > val;
  assign sts.eq       = $signed(rdata) == val;
  assign sts.ptr_zero = ptr == '0;
  assign sts.ptr_end  = ptr == cnt;
  assign sts.ptr_last = CW'(ptr + 1'b1) == cnt;
  assign sts.full     = cnt == CW'(CAPACITY);
  assign sts.empty    = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      ptr        <= '0;
      res_status <= sat_pkg::ST_OK;
      res_found  <= 1'b0;
      res_pos    <= '0;
    end else begin
      ptr <= ptr_next;
      case (cmd.cnt_op)
        sat_pkg::CNT_INC: cnt <= cnt + 1'b1;
        sat_pkg::CNT_DEC: cnt <= cnt - 1'b1;
        default:          cnt <= cnt;
      endcase
      if (cmd.res_clr) begin
        res_status <= sat_pkg::ST_OK;
        res_found  <= 1'b0;
        res_pos    <= '0;
      end
      if (cmd.res_set) begin
        res_status <= cmd.res_status;
      end
      if (cmd.res_hit) begin
        res_found <= 1'b1;
        res_pos   <= ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_val) begin
      val <= in_value;
    end
    if (cmd.out_ld) begin
      status   <= res_status;
      found    <= res_found;
      position <= 6'(res_pos);
      count    <= 7'(cnt);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == sat_pkg::CNT_INC |-> !sts.full)
    else $error("count increment on full table");

  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    res_found |-> res_status == sat_pkg::ST_OK)
    else $error("hit recorded with error status");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.we |-> ptr < CW'(CAPACITY))
    else $error("memory write beyond capacity");

endmodule

### sv/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// controller: decodes the operation and sequences the memory walk
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  sat_pkg::op_t     op_in,
  output logic             m_tvalid,
  input  logic             m_tready,
  output sat_pkg::dp_cmd_t cmd,
  input  sat_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SRCH,
    S_DEL,
    S_DONE
  } state_t;

  state_t       state;
  state_t       state_next;
  sat_pkg::op_t op;
  logic         accept;

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd            = '0;
    cmd.ptr_op     = sat_pkg::PTR_HOLD;
    cmd.rd_sel     = sat_pkg::RD_AT;
    cmd.cnt_op     = sat_pkg::CNT_HOLD;
    cmd.res_status = sat_pkg::ST_OK;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_val  = 1'b1;
          cmd.res_clr = 1'b1;
          case (op_in)
            sat_pkg::OP_INSERT: begin
              if (sts.full) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = sat_pkg::ST_FULL;
                state_next     = S_DONE;
              end else begin
                cmd.ptr_op = sat_pkg::PTR_COUNT;
                cmd.rd_sel = sat_pkg::RD_BELOW;
                state_next = S_INS;
              end
            end
            sat_pkg::OP_SEARCH: begin
              cmd.ptr_op = sat_pkg::PTR_ZERO;
              state_next = S_SRCH;
            end
            sat_pkg::OP_REMOVE_MIN: begin
              if (sts.empty) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = sat_pkg::ST_EMPTY;
                state_next     = S_DONE;
              end else begin
                cmd.ptr_op = sat_pkg::PTR_ZERO;
                cmd.rd_sel = sat_pkg::RD_ABOVE;
                state_next = S_DEL;
              end
            end
            sat_pkg::OP_REMOVE_MAX: begin
              if (sts.empty) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = sat_pkg::ST_EMPTY;
              end else begin
                cmd.cnt_op = sat_pkg::CNT_DEC;
              end
              state_next = S_DONE;
            end
            sat_pkg::OP_REMOVE_KEY: begin
              if (sts.empty) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = sat_pkg::ST_EMPTY;
                state_next     = S_DONE;
              end else begin
                cmd.ptr_op = sat_pkg::PTR_ZERO;
                state_next = S_SRCH;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_INS: begin
        cmd.we = 1'b1;
        if (sts.ptr_zero || !sts.gt) begin
          cmd.wr_val = 1'b1;
          cmd.cnt_op = sat_pkg::CNT_INC;
          state_next = S_DONE;
        end else begin
          cmd.ptr_op = sat_pkg::PTR_DEC;
          cmd.rd_sel = sat_pkg::RD_BELOW;
        end
      end
      S_SRCH: begin
        if (sts.ptr_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = sat_pkg::ST_NOT_FOUND;
          state_next     = S_DONE;
        end else if (sts.eq) begin
          cmd.res_hit = 1'b1;
          if (op == sat_pkg::OP_REMOVE_KEY) begin
            cmd.rd_sel = sat_pkg::RD_ABOVE;
            state_next = S_DEL;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.ptr_op = sat_pkg::PTR_INC;
        end
      end
      S_DEL: begin
        if (sts.ptr_last) begin
          cmd.cnt_op = sat_pkg::CNT_DEC;
          state_next = S_DONE;
        end else begin
          cmd.we     = 1'b1;
          cmd.ptr_op = sat_pkg::PTR_INC;
          cmd.rd_sel = sat_pkg::RD_ABOVE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      op       <= sat_pkg::OP_INSERT;
    end else begin
      state <= state_next;
      if (accept) begin
        op <= op_in;
      end
      if (cmd.out_ld) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("transfer accepted without starting work");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && m_tvalid && !m_tready |=> state == S_DONE)
    else $error("result slot overwritten while stalled");

endmodule
